@@ design/complex_arithmetic_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define CAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check on every clock edge, reset included
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, sideband type and saturation helper shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_SCALE = 3'd4,
        CMD_INC   = 3'd5,
        CMD_DEC   = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ov;
    } sat_t;

    // Control and finished results that ride beside the divider cells
    typedef struct packed {
        logic        vld;
        logic        is_div;
        logic        dz;
        logic        ov;
        logic        neg_r;
        logic        neg_i;
        logic        eov_r;
        logic        eov_i;
        logic [31:0] res_r;
        logic [31:0] res_i;
    } side_t;

    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        if (v > MAX66) begin
            r.val = 32'h7FFF_FFFF;
            r.ov  = 1'b1;
        end else if (v < MIN66) begin
            r.val = 32'h8000_0000;
            r.ov  = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/cau_front.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three stages: products, product sums, then rounding or divider setup.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_front import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic [2:0]         cmd,
    input  wire logic signed [31:0] a_real,
    input  wire logic signed [31:0] a_imag,
    input  wire logic signed [31:0] b_real,
    input  wire logic signed [31:0] b_imag,
    input  wire logic signed [15:0] scalar,
    output side_t                   side,
    output logic [63:0]             mag_r,
    output logic [63:0]             mag_i,
    output logic [63:0]             dvs
);

    // stage 1
    logic               vld1_reg;
    logic [2:0]         cmd1_reg;
    logic signed [63:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [63:0] m1_next, m4_next;
    sat_t               sim_r1_reg, sim_i1_reg, sim_r1_next, sim_i1_next;
    logic signed [31:0] yr;
    logic signed [65:0] one;

    // stage 2
    logic               vld2_reg;
    logic [2:0]         cmd2_reg;
    logic signed [64:0] sum_r_reg, sum_i_reg, sum_r_next, sum_i_next;
    logic [63:0]        d2_reg;
    sat_t               sim_r2_reg, sim_i2_reg, sim_r2_next, sim_i2_next;

    // stage 3
    side_t              side_reg, side_next;
    logic [63:0]        mag_r_reg, mag_i_reg, mag_r_next, mag_i_next, d3_reg;
    sat_t               mr, mi;

    assign one = 66'sd1 <<< FRAC_BITS;
    assign yr  = (cmd == CMD_SCALE) ? $signed({{16{scalar[15]}}, scalar}) : b_real;
    assign m1_next = a_real * yr;
    assign m4_next = a_imag * yr;

    always_comb begin
        sim_r1_next = '0;
        sim_i1_next = '0;
        case (cmd)
            CMD_ADD: begin
                sim_r1_next = sat32(66'(a_real) + 66'(b_real));
                sim_i1_next = sat32(66'(a_imag) + 66'(b_imag));
            end
            CMD_SUB: begin
                sim_r1_next = sat32(66'(a_real) - 66'(b_real));
                sim_i1_next = sat32(66'(a_imag) - 66'(b_imag));
            end
            CMD_INC: begin
                sim_r1_next = sat32(66'(a_real) + one);
                sim_i1_next = sat32(66'(a_imag) + one);
            end
            CMD_DEC: begin
                sim_r1_next = sat32(66'(a_real) - one);
                sim_i1_next = sat32(66'(a_imag) - one);
            end
            default: begin
                sim_r1_next = '0;
                sim_i1_next = '0;
            end
        endcase
    end

    always_comb begin
        sum_r_next  = 65'(m1_reg) + 65'(m2_reg);
        sum_i_next  = 65'(m4_reg) - 65'(m3_reg);
        sim_r2_next = sim_r1_reg;
        sim_i2_next = sim_i1_reg;
        case (cmd1_reg)
            CMD_MUL: begin
                sum_r_next = 65'(m1_reg) - 65'(m2_reg);
                sum_i_next = 65'(m3_reg) + 65'(m4_reg);
            end
            CMD_SCALE: begin
                sim_r2_next = sat32(66'(m1_reg));
                sim_i2_next = sat32(66'(m4_reg));
            end
            default: begin
                sim_r2_next = sim_r1_reg;
                sim_i2_next = sim_i1_reg;
            end
        endcase
    end

    assign mr = sat32(66'(sum_r_reg >>> FRAC_BITS));
    assign mi = sat32(66'(sum_i_reg >>> FRAC_BITS));

    always_comb begin
        side_next       = '0;
        side_next.vld   = vld2_reg;
        side_next.neg_r = sum_r_reg[64];
        side_next.neg_i = sum_i_reg[64];
        mag_r_next = sum_r_reg[64] ? 64'(-sum_r_reg) : sum_r_reg[63:0];
        mag_i_next = sum_i_reg[64] ? 64'(-sum_i_reg) : sum_i_reg[63:0];
        // integer quotient at or above 2^32 saturates before any fraction step
        side_next.eov_r = (d2_reg[63:32] == '0) && (mag_r_next[63:32] >= d2_reg[31:0]);
        side_next.eov_i = (d2_reg[63:32] == '0) && (mag_i_next[63:32] >= d2_reg[31:0]);
        case (cmd2_reg)
            CMD_MUL: begin
                side_next.res_r = mr.val;
                side_next.res_i = mi.val;
                side_next.ov    = mr.ov | mi.ov;
            end
            CMD_DIV: begin
                side_next.is_div = 1'b1;
                side_next.dz     = (d2_reg == '0);
            end
            default: begin
                side_next.res_r = sim_r2_reg.val;
                side_next.res_i = sim_i2_reg.val;
                side_next.ov    = sim_r2_reg.ov | sim_i2_reg.ov;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            side_reg.vld <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            side_reg <= side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg   <= cmd;
            m1_reg     <= m1_next;
            m2_reg     <= a_imag * b_imag;
            m3_reg     <= a_real * b_imag;
            m4_reg     <= m4_next;
            m5_reg     <= b_real * b_real;
            m6_reg     <= b_imag * b_imag;
            sim_r1_reg <= sim_r1_next;
            sim_i1_reg <= sim_i1_next;
            cmd2_reg   <= cmd1_reg;
            sum_r_reg  <= sum_r_next;
            sum_i_reg  <= sum_i_next;
            d2_reg     <= m5_reg[63:0] + m6_reg[63:0];
            sim_r2_reg <= sim_r2_next;
            sim_i2_reg <= sim_i2_next;
            mag_r_reg  <= mag_r_next;
            mag_i_reg  <= mag_i_next;
            d3_reg     <= d2_reg;
        end
    end

    assign side  = side_reg;
    assign mag_r = mag_r_reg;
    assign mag_i = mag_i_reg;
    assign dvs   = d3_reg;

endmodule
`default_nettype wire

@@ design/cau_div_cell.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider cell
// One restoring division step: shift in a numerator bit, compare, subtract.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_div_cell import cau_pkg::*; #(
    parameter int QW = 32 + FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [63:0]   d_in,
    input  wire logic [63:0]   rem_in,
    input  wire logic [31:0]   pend_in,
    input  wire logic [QW-1:0] q_in,
    output logic [63:0]        d_out,
    output logic [63:0]        rem_out,
    output logic [31:0]        pend_out,
    output logic [QW-1:0]      q_out
);

    logic [64:0]   t, diff;
    logic          ge;
    logic [63:0]   d_reg, rem_reg, rem_next;
    logic [31:0]   pend_reg;
    logic [QW-1:0] q_reg;

    assign t        = {rem_in, pend_in[31]};
    assign diff     = t - {1'b0, d_in};
    assign ge       = (t >= {1'b0, d_in});
    assign rem_next = ge ? diff[63:0] : t[63:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_in;
            rem_reg  <= rem_next;
            pend_reg <= {pend_in[30:0], 1'b0};
            q_reg    <= {q_in[QW-2:0], ge};
        end
    end

    assign d_out    = d_reg;
    assign rem_out  = rem_reg;
    assign pend_out = pend_reg;
    assign q_out    = q_reg;

endmodule
`default_nettype wire

@@ design/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined complex add, subtract, multiply, divide, scale, increment and
// decrement on signed fixed-point operands, with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per s_ handshake: s_tdata carries both complex operands
//   and the integer scalar, s_tuser the opcode. Each request yields exactly
//   one result on the m_ channel: m_tdata holds the saturated real and
//   imaginary parts, m_tuser the divide-by-zero and overflow flags.
//   Throughput: one request per cycle, sustained while no stall holds the pipeline.
//   Three front stages form the products, their sums and the divider setup;
//   a row of 32 + FRAC_BITS divider cells then produces one quotient bit
//   each; one output register applies the quotient sign and saturation.
//   Every operation walks the full pipeline so results stay in order.
//   Reset (aresetn low at a clock edge) empties the pipeline at once; hold
//   s_tready low while aresetn is low.
//   Stall: the whole pipeline holds while m_tvalid is high and m_tready is
//   low; s_tready drops in the same cycle, and resumes when the output
//   register drains or is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] a_real, [63:32] a_imag, [95:64] b_real, [127:96] b_imag,
    // [143:128] scalar
    input  wire logic [143:0] s_tdata,
    // [2:0] cmd
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] res_real, [63:32] res_imag
    output logic [63:0]       m_tdata,
    // [0] div_zero, [1] overflow
    output logic [1:0]        m_tuser
);

    localparam int NC = 32 + FRAC_BITS;   // one cell per quotient bit
    localparam int QW = 32 + FRAC_BITS;
    localparam logic [QW-1:0] Q_MAXP = QW'(32'h7FFF_FFFF);
    localparam logic [QW-1:0] Q_MAXN = QW'(33'h0_8000_0000);

    logic en;

    // chain taps: entry 0 comes from the front end, entry i+1 from cell i
    side_t         side_c [0:NC];
    logic [63:0]   d_c    [0:NC];
    logic [63:0]   remr_c [0:NC];
    logic [63:0]   remi_c [0:NC];
    logic [31:0]   pendr_c[0:NC];
    logic [31:0]   pendi_c[0:NC];
    logic [QW-1:0] qr_c   [0:NC];
    logic [QW-1:0] qi_c   [0:NC];
    logic [63:0]   mag_r, mag_i;

    // output register
    logic        out_vld_reg;
    logic [31:0] res_r_reg, res_i_reg, res_r_next, res_i_next;
    logic        dz_reg, ov_reg, dz_next, ov_next;
    sat_t        fr, fi;

    // advance whenever the output register is free or being taken
    assign en       = m_tready || !out_vld_reg;
    assign s_tready = en && aresetn;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .cmd     (s_tuser),
        .a_real  ($signed(s_tdata[31:0])),
        .a_imag  ($signed(s_tdata[63:32])),
        .b_real  ($signed(s_tdata[95:64])),
        .b_imag  ($signed(s_tdata[127:96])),
        .scalar  ($signed(s_tdata[143:128])),
        .side    (side_c[0]),
        .mag_r   (mag_r),
        .mag_i   (mag_i),
        .dvs     (d_c[0])
    );

    // upper numerator half seeds the remainder, lower half is shifted in
    assign remr_c[0]  = {32'd0, mag_r[63:32]};
    assign remi_c[0]  = {32'd0, mag_i[63:32]};
    assign pendr_c[0] = mag_r[31:0];
    assign pendi_c[0] = mag_i[31:0];
    assign qr_c[0]    = '0;
    assign qi_c[0]    = '0;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        logic [63:0] d_unused;

        cau_div_cell #(.QW(QW)) u_cell_r (
            .aclk     (aclk),
            .en       (en),
            .d_in     (d_c[i]),
            .rem_in   (remr_c[i]),
            .pend_in  (pendr_c[i]),
            .q_in     (qr_c[i]),
            .d_out    (d_c[i+1]),
            .rem_out  (remr_c[i+1]),
            .pend_out (pendr_c[i+1]),
            .q_out    (qr_c[i+1])
        );

        cau_div_cell #(.QW(QW)) u_cell_i (
            .aclk     (aclk),
            .en       (en),
            .d_in     (d_c[i]),
            .rem_in   (remi_c[i]),
            .pend_in  (pendi_c[i]),
            .q_in     (qi_c[i]),
            .d_out    (d_unused),
            .rem_out  (remi_c[i+1]),
            .pend_out (pendi_c[i+1]),
            .q_out    (qi_c[i+1])
        );

        // carry control and finished non-divide results beside the cells
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_c[i+1].vld <= 1'b0;
            end else if (en) begin
                side_c[i+1] <= side_c[i];
            end
        end
    end

    // apply sign to the quotient magnitude and saturate
    function automatic sat_t div_fin(input logic [QW-1:0] q, input logic neg,
                                     input logic eov);
        sat_t r;
        if (neg) begin
            if (eov || q > Q_MAXN) begin
                r.val = 32'h8000_0000;
                r.ov  = 1'b1;
            end else begin
                r.val = ~q[31:0] + 32'd1;
                r.ov  = 1'b0;
            end
        end else begin
            if (eov || q > Q_MAXP) begin
                r.val = 32'h7FFF_FFFF;
                r.ov  = 1'b1;
            end else begin
                r.val = q[31:0];
                r.ov  = 1'b0;
            end
        end
        return r;
    endfunction

    assign fr = div_fin(qr_c[NC], side_c[NC].neg_r, side_c[NC].eov_r);
    assign fi = div_fin(qi_c[NC], side_c[NC].neg_i, side_c[NC].eov_i);

    always_comb begin
        if (side_c[NC].is_div) begin
            if (side_c[NC].dz) begin
                // zero divisor: zero result, no overflow
                res_r_next = '0;
                res_i_next = '0;
                dz_next    = 1'b1;
                ov_next    = 1'b0;
            end else begin
                res_r_next = fr.val;
                res_i_next = fi.val;
                dz_next    = 1'b0;
                ov_next    = fr.ov | fi.ov;
            end
        end else begin
            res_r_next = side_c[NC].res_r;
            res_i_next = side_c[NC].res_i;
            dz_next    = 1'b0;
            ov_next    = side_c[NC].ov;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= side_c[NC].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_r_reg <= res_r_next;
            res_i_reg <= res_i_next;
            dz_reg    <= dz_next;
            ov_reg    <= ov_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {res_i_reg, res_r_reg};
    assign m_tuser  = {ov_reg, dz_reg};

    `CAU_ASSERT(a_ready_follows_output, s_tready == (m_tready || !m_tvalid), "s_tready does not track the output register")
    `CAU_ASSERT(a_dz_zero_result, (m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && m_tdata == 64'd0), "divide by zero result not clean")
    `CAU_ASSERT(a_ov_saturated, (m_tvalid && m_tuser[1]) |-> (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 || m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000), "overflow flagged without a saturated part")
    `CAU_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives random and corner-case requests through the stream input, predicts
// each result with an independent fixed-point model, checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb import cau_pkg::*;;

    localparam int FB        = 16;
    localparam int LATENCY   = 36 + FB;
    localparam int N_RANDOM  = 1750;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] scalar;
        logic [31:0] bi;
        logic [31:0] br;
        logic [31:0] ai;
        logic [31:0] ar;
    } req_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        ov;
    } cres_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    req_t  pending_reqs[$];
    cres_t expected_results[$];
    int    fail_count;
    int    cycle_count;
    bit    stim_done;
    int    burst_left;
    int    gap_left;

    complex_arithmetic_unit #(.FRAC_BITS(FB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Clamp to 32-bit signed range, flag when clipped
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ov);
        if (v > 128'sd2147483647) begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Quotient of num * 2^FB by den, truncated toward zero, then clamped
    function automatic logic [31:0] div_trunc(input logic signed [127:0] num,
                                              input logic signed [127:0] den,
                                              inout logic ov);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< FB) / den;
        if (num < 0)
            q = -q;
        return clamp32(q, ov);
    endfunction

    function automatic cres_t predict_complex(input req_t r);
        cres_t res;
        logic signed [127:0] ar, ai, br, bi, sc, one, d;
        logic ov;
        ar  = $signed(r.ar);
        ai  = $signed(r.ai);
        br  = $signed(r.br);
        bi  = $signed(r.bi);
        sc  = $signed(r.scalar);
        one = 128'sd1 <<< FB;
        ov  = 1'b0;
        res = '0;
        case (r.cmd)
            CMD_ADD: begin
                res.re = clamp32(ar + br, ov);
                res.im = clamp32(ai + bi, ov);
            end
            CMD_SUB: begin
                res.re = clamp32(ar - br, ov);
                res.im = clamp32(ai - bi, ov);
            end
            CMD_MUL: begin
                // arithmetic shift floors toward minus infinity
                res.re = clamp32((ar * br - ai * bi) >>> FB, ov);
                res.im = clamp32((ar * bi + ai * br) >>> FB, ov);
            end
            CMD_DIV: begin
                if (br == 0 && bi == 0) begin
                    res.dz = 1'b1;
                end else begin
                    d = br * br + bi * bi;
                    res.re = div_trunc(ar * br + ai * bi, d, ov);
                    res.im = div_trunc(ai * br - ar * bi, d, ov);
                end
            end
            CMD_SCALE: begin
                res.re = clamp32(ar * sc, ov);
                res.im = clamp32(ai * sc, ov);
            end
            CMD_INC: begin
                res.re = clamp32(ar + one, ov);
                res.im = clamp32(ai + one, ov);
            end
            CMD_DEC: begin
                res.re = clamp32(ar - one, ov);
                res.im = clamp32(ai - one, ov);
            end
            default: ;
        endcase
        res.ov = ov;
        return res;
    endfunction

    // Pick an operand part: mostly moderate values, sometimes extremes
    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom;
            4: return $urandom_range(0, 3) << FB;
            5, 6: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            default: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
        endcase
    endfunction

    task automatic add_req(input logic [2:0] cmd, input logic [31:0] ar, ai, br, bi,
                           input logic [15:0] sc);
        req_t r;
        r.cmd = cmd; r.ar = ar; r.ai = ai; r.br = br; r.bi = bi; r.scalar = sc;
        pending_reqs.push_back(r);
    endtask

    initial begin
        req_t r;
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        // Directed: every opcode, saturation in both directions, zero divisor,
        // unused opcode seven, extreme scalar values
        add_req(CMD_ADD, mx, mn, mx, mn, 16'h0);
        add_req(CMD_SUB, mn, mx, mx, mn, 16'h0);
        add_req(CMD_ADD, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'hFFFF_0000, 16'h0);
        add_req(CMD_MUL, mx, mx, mx, mx, 16'h0);
        add_req(CMD_MUL, mn, mn, mn, mn, 16'h0);
        add_req(CMD_MUL, mn, mx, mx, mn, 16'h0);
        add_req(CMD_MUL, 32'hFFFF_FFFF, 0, 32'h0000_0001, 0, 16'h0);
        add_req(CMD_DIV, mx, mx, 0, 0, 16'h0);
        add_req(CMD_DIV, mx, mn, 32'h1, 0, 16'h0);
        add_req(CMD_DIV, mn, mn, mn, mn, 16'h0);
        add_req(CMD_DIV, 32'h1_0000, 32'hFFFF_0000, 32'h3_0000, 32'h4_0000, 16'h0);
        add_req(CMD_DIV, 32'hFFFF_FFFF, 0, 32'h7_0000, 0, 16'h0);
        add_req(CMD_SCALE, mx, mn, 0, 0, 16'h7FFF);
        add_req(CMD_SCALE, mx, mn, 0, 0, 16'h8000);
        add_req(CMD_SCALE, 32'h1234, 32'hFFFF_1234, 0, 0, 16'hFFFF);
        add_req(CMD_INC, mx, 32'h7FFF_0000, 0, 0, 16'h0);
        add_req(CMD_DEC, mn, 32'h8001_0000, 0, 0, 16'h0);
        add_req(CMD_INC, mn, 0, 0, 0, 16'h0);
        add_req(CMD_DEC, mx, 0, 0, 0, 16'h0);
        add_req(3'd7, mx, mn, mx, mn, 16'hFFFF);
        for (int i = 0; i < N_RANDOM; i++) begin
            r.cmd    = $urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
            r.ar     = pick_part();
            r.ai     = pick_part();
            r.br     = pick_part();
            r.bi     = pick_part();
            r.scalar = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 64) - 32);
            if (r.cmd == CMD_DIV && $urandom_range(0, 9) == 0) begin
                r.br = '0;
                r.bi = '0;
            end
            pending_reqs.push_back(r);
        end
        stim_done = 1'b1;
    end

    // Reset and end-of-run control
    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (stim_done && pending_reqs.size() == 0 && !s_tvalid
              && expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Timeout watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > MAX_CYCLES) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Driver: bursts of requests separated by random gaps; drive on falling edge
    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        fail_count = 0;
        burst_left = 0;
        gap_left   = 0;
    end

    logic req_taken;
    always @(posedge aclk) req_taken <= aresetn && s_tvalid && s_tready;

    always @(negedge aclk) begin
        req_t r;
        if (aresetn) begin
            // advance past the request taken at the last rising edge
            if (req_taken)
                void'(pending_reqs.pop_front());
            if (!s_tvalid || req_taken) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    s_tvalid   <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {r.scalar, r.bi, r.br, r.ai, r.ar};
                    s_tuser  <= r.cmd;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            // receiver stall pattern: long ready runs mixed with choppy phases
            if (cycle_count[9])
                m_tready <= 1'b1;
            else if (cycle_count[7])
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 1) == 0);
        end
    end

    // Predict at acceptance; monitor checks results in order at rising edge
    always @(posedge aclk) begin
        cres_t exp_r;
        req_t  acc;
        if (aresetn && s_tvalid && s_tready) begin
            acc.ar     = s_tdata[31:0];
            acc.ai     = s_tdata[63:32];
            acc.br     = s_tdata[95:64];
            acc.bi     = s_tdata[127:96];
            acc.scalar = s_tdata[143:128];
            acc.cmd    = s_tuser;
            expected_results.push_back(predict_complex(acc));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: %h %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.re) begin
                    $error("res_real expected %h actual %h", exp_r.re, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== exp_r.im) begin
                    $error("res_imag expected %h actual %h", exp_r.im, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_r.dz) begin
                    $error("div_zero expected %b actual %b", exp_r.dz, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== exp_r.ov) begin
                    $error("overflow expected %b actual %b", exp_r.ov, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

endmodule
`default_nettype wire
